// ----- src/sccr_pkg.sv -----
package sccr_pkg;

    localparam int CMD_W = 2;
    localparam int RC_W  = 10;
    localparam int VAL_W = 64;
    localparam int IDX_W = 13;
    localparam int REG_W = 11;
    localparam int ST_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;
    localparam logic [REG_W-1:0]     REG_DIM_RST  = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD,
        CMD_FINISH,
        CMD_RD_PTR,
        CMD_RD_ENTRY
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_RANGE,
        ST_FULL,
        ST_NOT_DONE
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RESP,
        S_CLR,
        S_H_RD,
        S_H_CHK,
        S_H_WR,
        S_P_RD,
        S_P_WR,
        S_S_RD,
        S_S_CHK,
        S_S_WR
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic resp;
        logic clr;
        logic cnt_clr;
        logic acc_clr;
        logic h_rd;
        logic h_chk;
        logic h_wr;
        logic p_rd;
        logic p_wr;
        logic s_rd;
        logic s_chk;
        logic s_wr;
        logic fin;
    } t_ctl;

    typedef struct packed {
        logic k_end;
        logic clr_end;
        logic pre_end;
        logic is_finish;
        logic out_free;
    } t_sts;

endpackage

// ----- src/sccr_in_if.sv -----
interface sccr_in_if;
    logic                          valid;
    logic                          ready;
    logic [sccr_pkg::CMD_W-1:0]    cmd;
    logic [sccr_pkg::RC_W-1:0]     nonzero_row;
    logic [sccr_pkg::RC_W-1:0]     nonzero_col;
    logic [sccr_pkg::VAL_W-1:0]    nonzero_value;
    logic [sccr_pkg::IDX_W-1:0]    read_index;

    modport source (output valid, cmd, nonzero_row, nonzero_col, nonzero_value, read_index,
                    input ready);
    modport sink (input valid, cmd, nonzero_row, nonzero_col, nonzero_value, read_index,
                  output ready);
endinterface

// ----- src/sccr_out_if.sv -----
interface sccr_out_if;
    logic                          valid;
    logic                          ready;
    logic [sccr_pkg::ST_W-1:0]     status;
    logic [sccr_pkg::IDX_W-1:0]    pointer_out;
    logic [sccr_pkg::RC_W-1:0]     col_out;
    logic [sccr_pkg::VAL_W-1:0]    value_out;
    logic [sccr_pkg::IDX_W-1:0]    count_out;

    modport source (output valid, status, pointer_out, col_out, value_out, count_out,
                    input ready);
    modport sink (input valid, status, pointer_out, col_out, value_out, count_out,
                  output ready);
endinterface

// ----- src/sccr_cfg_if.sv -----
interface sccr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sccr_pkg::CFG_IDX_W-1:0]  index;
    logic [sccr_pkg::REG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/sccr_ctrl.sv -----
module sccr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sccr_in_if.sink        i_in,
    input  sccr_pkg::t_sts i_sts,
    output sccr_pkg::t_ctl o_ctl
);

    sccr_pkg::t_state r_state;
    sccr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sccr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = (r_state == sccr_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            sccr_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = sccr_pkg::S_EXEC;
                end
            end
            sccr_pkg::S_EXEC: begin
                o_ctl.exec = 1'b1;
                if (i_sts.is_finish) begin
                    o_ctl.acc_clr = 1'b1;
                    n_state       = sccr_pkg::S_CLR;
                end else begin
                    n_state = sccr_pkg::S_RESP;
                end
            end
            sccr_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.resp = 1'b1;
                    n_state    = sccr_pkg::S_IDLE;
                end
            end
            sccr_pkg::S_CLR: begin
                o_ctl.clr = 1'b1;
                if (i_sts.clr_end) begin
                    o_ctl.cnt_clr = 1'b1;
                    n_state       = sccr_pkg::S_H_RD;
                end
            end
            sccr_pkg::S_H_RD: begin
                if (i_sts.k_end) begin
                    o_ctl.acc_clr = 1'b1;
                    n_state       = sccr_pkg::S_P_RD;
                end else begin
                    o_ctl.h_rd = 1'b1;
                    n_state    = sccr_pkg::S_H_CHK;
                end
            end
            sccr_pkg::S_H_CHK: begin
                o_ctl.h_chk = 1'b1;
                n_state     = sccr_pkg::S_H_WR;
            end
            sccr_pkg::S_H_WR: begin
                o_ctl.h_wr = 1'b1;
                n_state    = sccr_pkg::S_H_RD;
            end
            sccr_pkg::S_P_RD: begin
                if (i_sts.pre_end) begin
                    o_ctl.cnt_clr = 1'b1;
                    n_state       = sccr_pkg::S_S_RD;
                end else begin
                    o_ctl.p_rd = 1'b1;
                    n_state    = sccr_pkg::S_P_WR;
                end
            end
            sccr_pkg::S_P_WR: begin
                o_ctl.p_wr = 1'b1;
                n_state    = sccr_pkg::S_P_RD;
            end
            sccr_pkg::S_S_RD: begin
                if (i_sts.k_end) begin
                    o_ctl.fin = 1'b1;
                    n_state   = sccr_pkg::S_RESP;
                end else begin
                    o_ctl.s_rd = 1'b1;
                    n_state    = sccr_pkg::S_S_CHK;
                end
            end
            sccr_pkg::S_S_CHK: begin
                o_ctl.s_chk = 1'b1;
                n_state     = sccr_pkg::S_S_WR;
            end
            sccr_pkg::S_S_WR: begin
                o_ctl.s_wr = 1'b1;
                n_state    = sccr_pkg::S_S_RD;
            end
            default: begin
                n_state = sccr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/sccr_dp.sv -----
module sccr_dp #(
    parameter int MAX_NONZEROS = 4096,
    parameter int MAX_DIM      = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sccr_in_if.sink        i_in,
    sccr_out_if.source     o_out,
    sccr_cfg_if.sink       i_cfg,
    input  sccr_pkg::t_ctl i_ctl,
    output sccr_pkg::t_sts o_sts
);

    localparam int KW = $clog2(MAX_NONZEROS + 1);
    localparam int NA = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int PA = $clog2(MAX_DIM + 1);
    localparam int DA = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam int RC_W  = sccr_pkg::RC_W;
    localparam int VAL_W = sccr_pkg::VAL_W;
    localparam int IDX_W = sccr_pkg::IDX_W;
    localparam int REG_W = sccr_pkg::REG_W;

    logic [REG_W-1:0] r_num_rows;
    logic [REG_W-1:0] r_num_cols;
    logic [REG_W-1:0] w_rows;
    logic [REG_W-1:0] w_cols;

    sccr_pkg::t_cmd    r_cmd;
    logic [RC_W-1:0]   r_row;
    logic [RC_W-1:0]   r_col;
    logic [VAL_W-1:0]  r_val;
    logic [IDX_W-1:0]  r_idx;

    logic [KW-1:0]     r_count;
    logic              r_fin;
    sccr_pkg::t_status r_ld_st;
    logic [KW-1:0]     r_k;
    logic [PA-1:0]     r_r;
    logic [KW-1:0]     r_acc;
    logic [RC_W-1:0]   r_hrow;
    logic              r_hok;

    logic [RC_W-1:0]   m_lrow [MAX_NONZEROS];
    logic [RC_W-1:0]   m_lcol [MAX_NONZEROS];
    logic [VAL_W-1:0]  m_lval [MAX_NONZEROS];
    logic [RC_W-1:0]   r_lrow_q;
    logic [RC_W-1:0]   r_lcol_q;
    logic [VAL_W-1:0]  r_lval_q;

    logic [KW-1:0]     m_ptr [MAX_DIM+1];
    logic [KW-1:0]     r_ptr_q;
    logic [KW-1:0]     m_cur [MAX_DIM];
    logic [KW-1:0]     r_cur_q;
    logic [RC_W-1:0]   m_ccol [MAX_NONZEROS];
    logic [VAL_W-1:0]  m_cval [MAX_NONZEROS];
    logic [RC_W-1:0]   r_ccol_q;
    logic [VAL_W-1:0]  r_cval_q;

    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [IDX_W-1:0]  r_o_ptr;
    logic [RC_W-1:0]   r_o_col;
    logic [VAL_W-1:0]  r_o_val;
    logic [IDX_W-1:0]  r_o_count;

    logic              w_ld_range;
    logic              w_ld_full;
    logic              w_ld_ok;

    logic              w_pw_en;
    logic [PA-1:0]     w_pw_addr;
    logic [KW-1:0]     w_pw_data;
    logic              w_pr_en;
    logic [PA-1:0]     w_pr_addr;
    logic              w_cw_en;
    logic [DA-1:0]     w_cw_addr;
    logic [KW-1:0]     w_cw_data;
    logic              w_vw_en;

    sccr_pkg::t_status w_st;
    logic [KW-1:0]     w_ptr;
    logic [RC_W-1:0]   w_col;
    logic [VAL_W-1:0]  w_val;

    // config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= sccr_pkg::REG_DIM_RST;
            r_num_cols <= sccr_pkg::REG_DIM_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == sccr_pkg::REG_NUM_ROWS) begin
                r_num_rows <= i_cfg.data;
            end else begin
                r_num_cols <= i_cfg.data;
            end
        end
    end

    assign w_rows = (32'(r_num_rows) > MAX_DIM) ? REG_W'(MAX_DIM) : r_num_rows;
    assign w_cols = (32'(r_num_cols) > MAX_DIM) ? REG_W'(MAX_DIM) : r_num_cols;

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd <= sccr_pkg::t_cmd'(i_in.cmd);
            r_row <= i_in.nonzero_row;
            r_col <= i_in.nonzero_col;
            r_val <= i_in.nonzero_value;
            r_idx <= i_in.read_index;
        end
    end

    assign w_ld_range = (32'(r_row) >= 32'(w_rows)) || (32'(r_col) >= 32'(w_cols));
    assign w_ld_full  = (32'(r_count) >= MAX_NONZEROS);
    assign w_ld_ok    = i_ctl.exec && (r_cmd == sccr_pkg::CMD_LOAD) && !w_ld_range && !w_ld_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fin   <= 1'b0;
        end else begin
            if (w_ld_ok) begin
                r_count <= r_count + KW'(1);
                r_fin   <= 1'b0;
            end else if (i_ctl.fin) begin
                r_fin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            if (w_ld_range) begin
                r_ld_st <= sccr_pkg::ST_RANGE;
            end else if (w_ld_full) begin
                r_ld_st <= sccr_pkg::ST_FULL;
            end else begin
                r_ld_st <= sccr_pkg::ST_OK;
            end
        end
    end

    // walk counters
    always_ff @(posedge i_clk) begin
        if (i_ctl.cnt_clr) begin
            r_k <= '0;
        end else if (i_ctl.h_wr || i_ctl.s_wr) begin
            r_k <= r_k + KW'(1);
        end
        if (i_ctl.acc_clr) begin
            r_r   <= '0;
            r_acc <= '0;
        end else if (i_ctl.clr) begin
            r_r <= r_r + PA'(1);
        end else if (i_ctl.p_wr) begin
            r_r   <= r_r + PA'(1);
            r_acc <= r_acc + r_ptr_q;
        end
        if (i_ctl.h_chk || i_ctl.s_chk) begin
            r_hrow <= r_lrow_q;
            r_hok  <= (32'(r_lrow_q) < 32'(w_rows));
        end
    end

    assign o_sts.k_end     = (r_k == r_count);
    assign o_sts.clr_end   = (32'(r_r) == MAX_DIM);
    assign o_sts.pre_end   = (32'(r_r) == 32'(w_rows));
    assign o_sts.is_finish = (r_cmd == sccr_pkg::CMD_FINISH);
    assign o_sts.out_free  = !r_out_valid || o_out.ready;

    // loaded entries
    always_ff @(posedge i_clk) begin
        if (w_ld_ok) begin
            m_lrow[r_count[NA-1:0]] <= r_row;
            m_lcol[r_count[NA-1:0]] <= r_col;
            m_lval[r_count[NA-1:0]] <= r_val;
        end
        if (i_ctl.h_rd || i_ctl.s_rd) begin
            r_lrow_q <= m_lrow[r_k[NA-1:0]];
            r_lcol_q <= m_lcol[r_k[NA-1:0]];
            r_lval_q <= m_lval[r_k[NA-1:0]];
        end
    end

    // row pointers
    always_comb begin
        w_pw_en   = 1'b0;
        w_pw_addr = r_r;
        w_pw_data = '0;
        if (i_ctl.clr) begin
            w_pw_en = 1'b1;
        end else if (i_ctl.h_wr) begin
            w_pw_en   = r_hok;
            w_pw_addr = PA'(32'(r_hrow) + 1);
            w_pw_data = r_ptr_q + KW'(1);
        end else if (i_ctl.p_wr) begin
            w_pw_en   = 1'b1;
            w_pw_addr = r_r + PA'(1);
            w_pw_data = r_acc + r_ptr_q;
        end
        w_pr_en   = i_ctl.h_chk || i_ctl.p_rd || i_ctl.exec;
        if (i_ctl.h_chk) begin
            w_pr_addr = PA'(32'(r_lrow_q) + 1);
        end else if (i_ctl.p_rd) begin
            w_pr_addr = r_r + PA'(1);
        end else if (r_cmd == sccr_pkg::CMD_RD_PTR) begin
            w_pr_addr = PA'(r_idx);
        end else begin
            w_pr_addr = PA'(w_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pw_en) begin
            m_ptr[w_pw_addr] <= w_pw_data;
        end
        if (w_pr_en) begin
            r_ptr_q <= m_ptr[w_pr_addr];
        end
    end

    // row cursors
    always_comb begin
        w_cw_en   = 1'b0;
        w_cw_addr = DA'(r_r);
        w_cw_data = r_acc;
        if (i_ctl.p_wr) begin
            w_cw_en = 1'b1;
        end else if (i_ctl.s_wr) begin
            w_cw_en   = r_hok;
            w_cw_addr = DA'(r_hrow);
            w_cw_data = r_cur_q + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw_en) begin
            m_cur[w_cw_addr] <= w_cw_data;
        end
        if (i_ctl.s_chk) begin
            r_cur_q <= m_cur[DA'(r_lrow_q)];
        end
    end

    // converted entries
    assign w_vw_en = i_ctl.s_wr && r_hok && (32'(r_cur_q) < MAX_NONZEROS);

    always_ff @(posedge i_clk) begin
        if (w_vw_en) begin
            m_ccol[NA'(r_cur_q)] <= r_lcol_q;
            m_cval[NA'(r_cur_q)] <= r_lval_q;
        end
        if (i_ctl.exec) begin
            r_ccol_q <= m_ccol[NA'(r_idx)];
            r_cval_q <= m_cval[NA'(r_idx)];
        end
    end

    // result
    always_comb begin
        w_st  = sccr_pkg::ST_OK;
        w_ptr = '0;
        w_col = '0;
        w_val = '0;
        unique case (r_cmd)
            sccr_pkg::CMD_LOAD: begin
                w_st = r_ld_st;
            end
            sccr_pkg::CMD_FINISH: begin
                w_st = sccr_pkg::ST_OK;
            end
            sccr_pkg::CMD_RD_PTR: begin
                if (!r_fin) begin
                    w_st = sccr_pkg::ST_NOT_DONE;
                end else if (32'(r_idx) > 32'(w_rows)) begin
                    w_st = sccr_pkg::ST_RANGE;
                end else begin
                    w_ptr = r_ptr_q;
                end
            end
            sccr_pkg::CMD_RD_ENTRY: begin
                if (!r_fin) begin
                    w_st = sccr_pkg::ST_NOT_DONE;
                end else if ((32'(r_idx) >= 32'(r_ptr_q)) || (32'(r_idx) >= MAX_NONZEROS)) begin
                    w_st = sccr_pkg::ST_RANGE;
                end else begin
                    w_col = r_ccol_q;
                    w_val = r_cval_q;
                end
            end
            default: begin
                w_st = sccr_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.resp) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.resp) begin
            r_o_status <= w_st;
            r_o_ptr    <= IDX_W'(w_ptr);
            r_o_col    <= w_col;
            r_o_val    <= w_val;
            r_o_count  <= IDX_W'(r_count);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_o_status;
    assign o_out.pointer_out = r_o_ptr;
    assign o_out.col_out     = r_o_col;
    assign o_out.value_out   = r_o_val;
    assign o_out.count_out   = r_o_count;

endmodule

// ----- src/sparse_csc_to_csr_converter_unit.sv -----
// CSC to CSR sparse matrix converter.
// i_in carries commands: load a nonzero, finish the conversion, read a row
// pointer or read a converted entry. o_out returns one item per command with
// status, read data and the running nonzero count. i_cfg writes num_rows
// (index 0) and num_cols (index 1); it is always ready.
// Load and read commands pass through the accept, execute and result steps of
// the controller, and the block takes no new command until the result of the
// last one is registered.
// Finish runs a controller sequence: a clear of all MAX_DIM+1 pointer table
// entries, a histogram walk over the nonzeros, a prefix pass over the rows and
// a scatter walk over the nonzeros, then the result.
// Reset clears the count, the finished flag and the handshake state; the
// stores need no clearing pass. Results sit in an output register; a stalled
// receiver holds the block after the next command is taken until that
// register frees up.
module sparse_csc_to_csr_converter_unit #(
    parameter int MAX_NONZEROS = 4096,
    parameter int MAX_DIM      = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sccr_in_if.sink     i_in,
    sccr_out_if.source  o_out,
    sccr_cfg_if.sink    i_cfg
);

    sccr_pkg::t_ctl w_ctl;
    sccr_pkg::t_sts w_sts;

    sccr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    sccr_dp #(
        .MAX_NONZEROS (MAX_NONZEROS),
        .MAX_DIM      (MAX_DIM)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts)
    );

endmodule

// ----- test/tb_sparse_csc_to_csr_converter_unit.sv -----
`timescale 1ns / 1ps

module tb_sparse_csc_to_csr_converter_unit;

    localparam int NZ_MAX  = 4096;
    localparam int DIM_MAX = 1024;
    localparam int WATCHDOG_LIMIT = 200000;

    localparam int RC_W  = sccr_pkg::RC_W;
    localparam int VAL_W = sccr_pkg::VAL_W;
    localparam int IDX_W = sccr_pkg::IDX_W;
    localparam int REG_W = sccr_pkg::REG_W;

    typedef struct packed {
        sccr_pkg::t_cmd         cmd;
        logic [RC_W-1:0]        row;
        logic [RC_W-1:0]        col;
        logic [VAL_W-1:0]       value;
        logic [IDX_W-1:0]       index;
    } t_cmd_item;

    typedef struct packed {
        sccr_pkg::t_status      status;
        logic [IDX_W-1:0]       pointer;
        logic [RC_W-1:0]        col;
        logic [VAL_W-1:0]       value;
        logic [IDX_W-1:0]       count;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    sccr_in_if  in_ch();
    sccr_out_if out_ch();
    sccr_cfg_if cfg_ch();

    sparse_csc_to_csr_converter_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // converter state mirror
    int unsigned mdl_rows, mdl_cols;
    logic [IDX_W-1:0]  mdl_ptr [DIM_MAX+1];
    logic [IDX_W-1:0]  mdl_cursor [DIM_MAX];
    logic [RC_W-1:0]   mdl_ld_row [NZ_MAX];
    logic [RC_W-1:0]   mdl_ld_col [NZ_MAX];
    logic [VAL_W-1:0]  mdl_ld_val [NZ_MAX];
    logic [RC_W-1:0]   mdl_cv_col [NZ_MAX];
    logic [VAL_W-1:0]  mdl_cv_val [NZ_MAX];
    int unsigned mdl_count;
    bit mdl_done;

    t_cmd_item cmd_queue[$];
    t_result   expected_results[$];
    t_cmd_item cfg_queue[$];

    int send_idle_pct, recv_stall_pct;
    bit failed, timed_out;
    int quiet_cycles;

    function automatic int unsigned clamp_dim(int unsigned v);
        return v > DIM_MAX ? DIM_MAX : v;
    endfunction

    task automatic build_csr();
        int unsigned rows;
        int unsigned pos;
        rows = clamp_dim(mdl_rows);
        for (int r = 0; r <= DIM_MAX; r++) mdl_ptr[r] = '0;
        for (int k = 0; k < mdl_count; k++)
            if (mdl_ld_row[k] < rows) mdl_ptr[mdl_ld_row[k] + 1]++;
        for (int r = 0; r < rows; r++) mdl_ptr[r+1] += mdl_ptr[r];
        for (int r = 0; r < rows; r++) mdl_cursor[r] = mdl_ptr[r];
        for (int k = 0; k < mdl_count; k++) begin
            if (mdl_ld_row[k] < rows) begin
                pos = mdl_cursor[mdl_ld_row[k]];
                if (pos < NZ_MAX) begin
                    mdl_cv_col[pos] = mdl_ld_col[k];
                    mdl_cv_val[pos] = mdl_ld_val[k];
                end
                mdl_cursor[mdl_ld_row[k]] = IDX_W'(pos + 1);
            end
        end
        mdl_done = 1'b1;
    endtask

    task automatic predict_result(input t_cmd_item it);
        t_result r;
        int unsigned rows, cols, total;
        rows = clamp_dim(mdl_rows);
        cols = clamp_dim(mdl_cols);
        r = '0;
        r.status = sccr_pkg::ST_OK;
        case (it.cmd)
            sccr_pkg::CMD_LOAD: begin
                if (it.row >= rows || it.col >= cols) r.status = sccr_pkg::ST_RANGE;
                else if (mdl_count >= NZ_MAX) r.status = sccr_pkg::ST_FULL;
                else begin
                    mdl_ld_row[mdl_count] = it.row;
                    mdl_ld_col[mdl_count] = it.col;
                    mdl_ld_val[mdl_count] = it.value;
                    mdl_count++;
                    mdl_done = 1'b0;
                end
            end
            sccr_pkg::CMD_FINISH: build_csr();
            default: begin
                if (!mdl_done) r.status = sccr_pkg::ST_NOT_DONE;
                else if (it.cmd == sccr_pkg::CMD_RD_PTR) begin
                    if (it.index > rows) r.status = sccr_pkg::ST_RANGE;
                    else r.pointer = mdl_ptr[it.index];
                end else begin
                    total = mdl_ptr[rows];
                    if (it.index >= total || it.index >= NZ_MAX) r.status = sccr_pkg::ST_RANGE;
                    else begin
                        r.col = mdl_cv_col[it.index];
                        r.value = mdl_cv_val[it.index];
                    end
                end
            end
        endcase
        r.count = IDX_W'(mdl_count);
        expected_results.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_result(cmd_queue.pop_front());
            end
            if ((!in_ch.valid || in_ch.ready) && cmd_queue.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                t_cmd_item nx;
                nx = cmd_queue[0];
                in_ch.valid <= 1'b1;
                in_ch.cmd <= nx.cmd;
                in_ch.nonzero_row <= nx.row;
                in_ch.nonzero_col <= nx.col;
                in_ch.nonzero_value <= nx.value;
                in_ch.read_index <= nx.index;
            end else if (in_ch.valid && in_ch.ready) begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // configuration writer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == sccr_pkg::REG_NUM_ROWS) mdl_rows = cfg_ch.data;
                else mdl_cols = cfg_ch.data;
                cfg_ch.valid <= 1'b0;
            end else if (!cfg_ch.valid && cfg_queue.size() > 0) begin
                t_cmd_item c;
                c = cfg_queue.pop_front();
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= c.row[0];
                cfg_ch.data <= c.index[REG_W-1:0];
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_result e;
                if (expected_results.size() == 0) begin
                    $error("unexpected result item");
                    failed = 1'b1;
                end else begin
                    e = expected_results.pop_front();
                    if (out_ch.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, out_ch.status);
                        failed = 1'b1;
                    end
                    if (out_ch.pointer_out !== e.pointer) begin
                        $error("pointer_out exp %0d got %0d", e.pointer, out_ch.pointer_out);
                        failed = 1'b1;
                    end
                    if (out_ch.col_out !== e.col) begin
                        $error("col_out exp %0d got %0d", e.col, out_ch.col_out);
                        failed = 1'b1;
                    end
                    if (out_ch.value_out !== e.value) begin
                        $error("value_out exp %h got %h", e.value, out_ch.value_out);
                        failed = 1'b1;
                    end
                    if (out_ch.count_out !== e.count) begin
                        $error("count_out exp %0d got %0d", e.count, out_ch.count_out);
                        failed = 1'b1;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                    (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_cmd_item mk(sccr_pkg::t_cmd c, int unsigned r, int unsigned co,
                                     logic [VAL_W-1:0] v, int unsigned ix);
        t_cmd_item it;
        it.cmd = c;
        it.row = RC_W'(r);
        it.col = RC_W'(co);
        it.value = v;
        it.index = IDX_W'(ix);
        return it;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned val);
        cfg_queue.push_back(mk(sccr_pkg::CMD_LOAD, idx, 0, '0, val));
        do @(negedge i_clk); while (cfg_queue.size() > 0 || cfg_ch.valid);
    endtask

    // one matrix: column-ordered loads with random strays, an optional early read, finish, then reads
    task automatic queue_matrix(int unsigned nnz, int unsigned rows, int unsigned cols);
        int unsigned c;
        int unsigned r_lim, c_lim;
        r_lim = clamp_dim(rows);
        c_lim = clamp_dim(cols);
        c = 0;
        for (int k = 0; k < nnz; k++) begin
            if ($urandom_range(9) == 0)
                cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, $urandom_range(1023),
                                       $urandom_range(1023), rand_value(),
                                       $urandom_range(8191)));
            else begin
                if (c < c_lim - 1 && $urandom_range(2) == 0) c = $urandom_range(c_lim - 1, c);
                cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, $urandom_range(r_lim - 1), c,
                                       rand_value(), $urandom_range(8191)));
            end
        end
        if ($urandom_range(3) == 0)
            cmd_queue.push_back(mk(sccr_pkg::CMD_RD_ENTRY, 0, 0, '0, $urandom_range(8191)));
        cmd_queue.push_back(mk(sccr_pkg::CMD_FINISH, $urandom_range(1023), $urandom_range(1023),
                               rand_value(), $urandom_range(8191)));
        for (int k = 0; k < nnz / 2 + 4; k++) begin
            if ($urandom_range(1))
                cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, rand_value(),
                    $urandom_range(5) == 0 ? $urandom_range(8191) : $urandom_range(r_lim)));
            else
                cmd_queue.push_back(mk(sccr_pkg::CMD_RD_ENTRY, 0, 0, rand_value(),
                    $urandom_range(5) == 0 ? $urandom_range(8191) : $urandom_range(nnz + 1)));
        end
    endtask

    initial begin
        int sent;
        int unsigned rows, cols;
        failed = 1'b0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mdl_rows = sccr_pkg::REG_DIM_RST;
        mdl_cols = sccr_pkg::REG_DIM_RST;
        mdl_count = 0;
        mdl_done = 1'b0;
        for (int r = 0; r <= DIM_MAX; r++) mdl_ptr[r] = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = sccr_pkg::CMD_LOAD;
        in_ch.nonzero_row = '0;
        in_ch.nonzero_col = '0;
        in_ch.nonzero_value = '0;
        in_ch.read_index = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads before finish, extremes, range errors, repeat finish
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_ENTRY, 0, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 0, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 1023, 1023, '1, 8191));
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 5, 3, 64'hA5A5_5A5A_0F0F_F0F0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 5, 1, 64'h5A5A_A5A5_F0F0_0F0F, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_FINISH, 0, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_FINISH, 0, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, 6));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, 1024));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, 1025));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, 8191));
        for (int i = 0; i < 4; i++) cmd_queue.push_back(mk(sccr_pkg::CMD_RD_ENTRY, 0, 0, '0, i));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_ENTRY, 0, 0, '0, 8191));
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 2, 0, 64'h1, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, 0));
        wait_drained();

        // narrow dims: stale rows dropped, out-of-range loads, zero dims
        write_reg(sccr_pkg::REG_NUM_ROWS, 4);
        write_reg(sccr_pkg::REG_NUM_COLS, 2);
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 4, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 0, 2, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 3, 1, 64'h77, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_FINISH, 0, 0, '0, 0));
        for (int i = 0; i <= 5; i++) cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, i));
        for (int i = 0; i < 3; i++) cmd_queue.push_back(mk(sccr_pkg::CMD_RD_ENTRY, 0, 0, '0, i));
        wait_drained();
        write_reg(sccr_pkg::REG_NUM_ROWS, 0);
        write_reg(sccr_pkg::REG_NUM_COLS, 2047);
        cmd_queue.push_back(mk(sccr_pkg::CMD_LOAD, 0, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_FINISH, 0, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, 0));
        cmd_queue.push_back(mk(sccr_pkg::CMD_RD_PTR, 0, 0, '0, 1));
        wait_drained();

        // random phases with idling mixes and settings
        sent = 0;
        for (int ph = 0; sent < 750; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            case (ph % 5)
                0: begin rows = 1024; cols = 1024; end
                1: begin rows = 1; cols = 1; end
                2: begin rows = 2047; cols = 1500; end
                default: begin rows = $urandom_range(1, 64); cols = $urandom_range(1, 64); end
            endcase
            write_reg(sccr_pkg::REG_NUM_ROWS, rows);
            write_reg(sccr_pkg::REG_NUM_COLS, cols);
            begin
                int unsigned n;
                n = $urandom_range(1, 24);
                queue_matrix(n, rows, cols);
                sent += n + n / 2 + 5;
            end
            wait_drained();
        end

        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
